/* hdl/kflerp_pkg.sv */
// kflerp_pkg: shared codes, register reset values and size defaults for the
// keyframe table lerp sampler. No dependencies; used by all but kflerp_store.

package kflerp_pkg;

    // Item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_ALL  = 2'd1;
    localparam logic [1:0] KIND_ONE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BEGIN_TIME  = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd2;
    localparam logic [1:0] CFG_CURVE_COUNT = 2'd3;

    // Register reset values
    localparam logic [31:0] RST_BEGIN_TIME  = 32'd0;
    localparam logic [31:0] RST_SAMPLE_RATE = 32'd1966080;  // 30.0 in Q16.16
    localparam logic [8:0]  RST_FRAME_COUNT = 9'd1;
    localparam logic [6:0]  RST_CURVE_COUNT = 7'd1;

    // Table size defaults
    localparam int DEF_MAX_FRAMES = 256;
    localparam int DEF_MAX_CURVES = 16;

endpackage

/* hdl/kflerp_store.sv */
// kflerp_store: keyframe sample memory, one write port and two registered read ports.
// Standalone; instantiated by keyframe_table_lerp_sampler_unit.

module kflerp_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [31:0]   o_rdata_a,
    output logic [31:0]   o_rdata_b
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds between reads for the sequencer's difference and add stages
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/keyframe_table_lerp_sampler_unit.sv */
// keyframe_table_lerp_sampler_unit: top level, sequencer around one shared multiplier.
// Depends on kflerp_pkg and kflerp_store.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one item per beat: a load
//   (kind 0) writes one Q16.16 sample at frame_sel, curve_sel; a query
//   (kind 1 all curves, kind 2 one curve) samples the table at query_time.
//   Output channel (o_valid / i_ready) carries one result per beat; o_last
//   marks the final result of a query.
//   Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data;
//   write only while the block is idle.
//   Sequence: a load is written when it is accepted. A query first
//   locates the frame pair (subtract, shared multiply by the rate,
//   clamp), then runs each curve through memory read, difference,
//   shared multiply, add and saturate. The single multiplier is used
//   once to locate and once per curve.
//   o_ready is high only between queries; the next item is taken while
//   the final result still sits in the output register.
//   Stall: a held result keeps the sequencer waiting in its add stage.
//   Reset (synchronous, active low) returns state and configuration
//   registers to their defaults and drops o_valid; the table is not cleared.

module keyframe_table_lerp_sampler_unit #(
    parameter int MAX_FRAMES = kflerp_pkg::DEF_MAX_FRAMES,
    parameter int MAX_CURVES = kflerp_pkg::DEF_MAX_CURVES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic signed [31:0] i_query_time,
    input  logic [5:0]  i_curve_sel,
    input  logic [7:0]  i_frame_sel,
    input  logic signed [31:0] i_load_value,
    // results
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_sample_value,
    output logic [5:0]  o_curve_out,
    output logic        o_last
);

    import kflerp_pkg::*;

    localparam int DEPTH = MAX_FRAMES * MAX_CURVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_FRAMES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUB  = 8'b0000_0010,
        S_LMUL = 8'b0000_0100,
        S_LOC  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_DIF  = 8'b0010_0000,
        S_BMUL = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_begin;
    logic [31:0] r_rate;
    logic [8:0]  r_fcount;
    logic [6:0]  r_ccount;

    // query registers
    logic [31:0]        r_qt;
    logic               r_all;
    logic               r_zero;
    logic [5:0]         r_curve;
    logic [5:0]         r_ncm1;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [63:0]        r_prod;
    logic [AW-1:0]      r_row_a;
    logic [AW-1:0]      r_row_b;
    logic signed [16:0] r_u;
    logic signed [32:0] r_dif;

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_oval;
    logic [5:0]         r_ocurve;
    logic               r_olast;

    logic              in_acc;
    logic              out_acc;
    logic              out_free;
    logic              is_last;
    logic [FW-1:0]     top_frame;
    logic [5:0]        ncm1;
    logic              load_ok;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [31:0]       rd_a;
    logic [31:0]       rd_b;
    logic signed [32:0] diff_t;
    logic signed [32:0] mul_x;
    logic signed [32:0] mul_y;
    logic signed [65:0] mul_p;
    logic [31:0]       ip;
    logic [15:0]       fr;
    logic [FW-1:0]     fa;
    logic [FW-1:0]     fb;
    logic signed [49:0] bp;
    logic signed [34:0] vsum;
    logic signed [31:0] vsat;

    assign in_acc   = i_valid && o_ready;
    assign out_acc  = r_ovalid && i_ready;
    assign out_free = !r_ovalid || i_ready;
    assign is_last  = !r_all || (r_curve == r_ncm1);

    // effective counts, zero read as one, large values held to the table size
    always_comb begin
        if (r_fcount == 9'd0) begin
            top_frame = '0;
        end else if (32'(r_fcount) > 32'(MAX_FRAMES)) begin
            top_frame = FW'(MAX_FRAMES - 1);
        end else begin
            top_frame = FW'(32'(r_fcount) - 32'd1);
        end
        if (r_ccount == 7'd0) begin
            ncm1 = 6'd0;
        end else if (32'(r_ccount) > 32'(MAX_CURVES)) begin
            ncm1 = 6'(MAX_CURVES - 1);
        end else begin
            ncm1 = 6'(r_ccount - 7'd1);
        end
    end

    // sample store
    assign load_ok = in_acc && (i_kind == KIND_LOAD)
                     && (32'(i_frame_sel) < 32'(MAX_FRAMES))
                     && (32'(i_curve_sel) < 32'(MAX_CURVES));
    assign waddr   = AW'(AW'(i_frame_sel) * AW'(MAX_CURVES) + AW'(i_curve_sel));
    assign raddr_a = AW'(r_row_a + AW'(r_curve));
    assign raddr_b = AW'(r_row_b + AW'(r_curve));

    kflerp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (load_ok),
        .i_waddr   (waddr),
        .i_wdata   (i_load_value),
        .i_re      ((r_state == S_RD) && !r_zero),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // shared multiplier: |d| * rate for locate, (b - a) * u for blend
    always_comb begin
        if (r_state == S_LMUL) begin
            mul_x = $signed({1'b0, r_mag});
            mul_y = $signed({1'b0, r_rate});
        end else begin
            mul_x = r_dif;
            mul_y = $signed({{16{r_u[16]}}, r_u});
        end
        mul_p = mul_x * mul_y;
    end

    assign diff_t = $signed({r_qt[31], r_qt}) - $signed({r_begin[31], r_begin});

    // frame pair, clamped to the table in use
    assign ip = r_prod[63:32];
    assign fr = r_prod[31:16];
    always_comb begin
        if (r_neg) begin
            fa = '0;
            fb = ((ip == 32'd0) && (top_frame != '0)) ? FW'(1) : '0;
        end else begin
            fa = (ip > 32'(top_frame)) ? top_frame : FW'(ip);
            fb = (ip >= 32'(top_frame)) ? top_frame : FW'(ip + 32'd1);
        end
    end

    // a + trunc((b - a) * u / 2^16), rounding toward zero via carry-in
    assign bp   = $signed(r_prod[49:0]);
    always_comb begin
        vsum = 35'($signed(rd_a)) + 35'(bp >>> 16)
               + 35'({34'd0, bp[49] && (bp[15:0] != 16'd0)});
        if (vsum > 35'sd2147483647) begin
            vsat = 32'sh7FFF_FFFF;
        end else if (vsum < -35'sd2147483648) begin
            vsat = 32'sh8000_0000;
        end else begin
            vsat = vsum[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && ((i_kind == KIND_ALL) || (i_kind == KIND_ONE))) begin
                    n_state = S_SUB;
                end
            end
            S_SUB:  n_state = S_LMUL;
            S_LMUL: n_state = S_LOC;
            S_LOC:  n_state = S_RD;
            S_RD:   n_state = S_DIF;
            S_DIF:  n_state = S_BMUL;
            S_BMUL: n_state = S_SUM;
            S_SUM: begin
                if (out_free) begin
                    n_state = is_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_begin  <= RST_BEGIN_TIME;
            r_rate   <= RST_SAMPLE_RATE;
            r_fcount <= RST_FRAME_COUNT;
            r_ccount <= RST_CURVE_COUNT;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BEGIN_TIME:  r_begin  <= i_cfg_data;
                    CFG_SAMPLE_RATE: r_rate   <= i_cfg_data;
                    CFG_FRAME_COUNT: r_fcount <= i_cfg_data[8:0];
                    CFG_CURVE_COUNT: r_ccount <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if ((r_state == S_SUM) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_qt    <= i_query_time;
                    r_all   <= (i_kind == KIND_ALL);
                    r_ncm1  <= ncm1;
                    r_curve <= (i_kind == KIND_ALL) ? 6'd0 : i_curve_sel;
                    r_zero  <= (i_kind == KIND_ONE) && (i_curve_sel > ncm1);
                end
            end
            S_SUB: begin
                r_neg <= diff_t[32];
                r_mag <= diff_t[32] ? 32'(-diff_t) : diff_t[31:0];
            end
            S_LMUL, S_BMUL: begin
                r_prod <= mul_p[63:0];
            end
            S_LOC: begin
                r_row_a <= AW'(AW'(fa) * AW'(MAX_CURVES));
                r_row_b <= AW'(AW'(fb) * AW'(MAX_CURVES));
                r_u     <= r_neg ? -$signed({1'b0, fr}) : $signed({1'b0, fr});
            end
            S_DIF: begin
                r_dif <= $signed({rd_b[31], rd_b}) - $signed({rd_a[31], rd_a});
            end
            S_SUM: begin
                if (out_free) begin
                    r_oval   <= r_zero ? 32'sd0 : vsat;
                    r_ocurve <= r_curve;
                    r_olast  <= is_last;
                    r_curve  <= r_curve + 6'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_sample_value = r_oval;
    assign o_curve_out    = r_ocurve;
    assign o_last         = r_olast;

endmodule

/* hdl/kflerp_checker.sv */
// kflerp_props: port-level assertions for keyframe_table_lerp_sampler_unit,
// bound to the top level below. Depends on kflerp_pkg.

module kflerp_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_sample_value,
    input logic [5:0]  o_curve_out,
    input logic        o_last
);

    import kflerp_pkg::*;

    // a held result beat does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_value)
                                && $stable(o_curve_out) && $stable(o_last))
        else $error("result beat changed while stalled");

    // a query keeps the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && ((i_kind == KIND_ALL) || (i_kind == KIND_ONE))
        |=> !o_ready)
        else $error("input taken again right after a query");

    // while a non-final beat is shown, more curves are pending
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("block idle in the middle of a run");

    // reset drops the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind keyframe_table_lerp_sampler_unit kflerp_props u_kflerp_props (.*);

/* verif/kflerp_checker.sv */
// kflerp_checker: passive monitor for the keyframe table lerp sampler. Tracks the
// register port, keeps a shadow of the sample table, predicts every result beat.
// Depends on kflerp_pkg.

module kflerp_checker
    import kflerp_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int MAX_CURVES = DEF_MAX_CURVES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_query_time,
    input  logic [5:0]  i_curve_sel,
    input  logic [7:0]  i_frame_sel,
    input  logic [31:0] i_load_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_sample_value,
    input  logic [5:0]  i_curve_out,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  curve;
        logic        last;
    } t_result_beat;

    t_result_beat expected_beats[$];
    logic [31:0]  sample_shadow [MAX_FRAMES * MAX_CURVES];
    logic [31:0]  begin_time_r;
    logic [31:0]  sample_rate_r;
    logic [8:0]   frame_count_r;
    logic [6:0]   curve_count_r;
    int           fail_total = 0;
    int           pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic longint frames_in_use();
        if (frame_count_r == 0) return 1;
        if (frame_count_r > MAX_FRAMES) return MAX_FRAMES;
        return longint'(frame_count_r);
    endfunction

    function automatic int curves_in_use();
        if (curve_count_r == 0) return 1;
        if (curve_count_r > MAX_CURVES) return MAX_CURVES;
        return int'(curve_count_r);
    endfunction

    function automatic longint clamp_frame(input longint idx);
        longint top_frame;
        top_frame = frames_in_use() - 1;
        if (idx < 0) return 0;
        if (idx > top_frame) return top_frame;
        return idx;
    endfunction

    // frac is signed Q0.16; negative means extrapolation below row_a
    function automatic logic [31:0] lerp_sample(input longint row_a, input longint row_b,
                                                input int curve, input longint frac);
        longint a;
        longint b;
        longint v;
        a = longint'($signed(sample_shadow[row_a * MAX_CURVES + curve]));
        b = longint'($signed(sample_shadow[row_b * MAX_CURVES + curve]));
        v = a + ((b - a) * frac) / 65536;
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return v[31:0];
    endfunction

    task automatic predict_query(input logic [1:0] kind, input logic [31:0] qt,
                                 input logic [5:0] csel);
        longint       delta;
        longint       whole;
        longint       idx;
        longint       frac;
        longint       row_a;
        longint       row_b;
        logic [63:0]  mag;
        logic [63:0]  prod;
        int           n_curves;
        int           c;
        bit           neg;
        t_result_beat beat;
        delta = longint'($signed(qt)) - longint'($signed(begin_time_r));
        neg   = (delta < 0);
        mag   = neg ? -delta : delta;
        // Q16.16 time times Q16.16 rate: Q32.32, both parts truncated toward zero
        prod  = mag * {32'd0, sample_rate_r};
        whole = longint'({32'd0, prod[63:32]});
        frac  = longint'({48'd0, prod[31:16]});
        idx   = neg ? -whole : whole;
        if (neg) frac = -frac;
        row_a = clamp_frame(idx);
        row_b = clamp_frame(idx + 1);
        n_curves = curves_in_use();
        if (kind == KIND_ONE) begin
            beat.value = (csel < n_curves) ? lerp_sample(row_a, row_b, csel, frac) : '0;
            beat.curve = csel;
            beat.last  = 1'b1;
            expected_beats.push_back(beat);
        end else begin
            for (c = 0; c < n_curves; c++) begin
                beat.value = lerp_sample(row_a, row_b, c, frac);
                beat.curve = 6'(c);
                beat.last  = (c == n_curves - 1);
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic note_failure(input string what);
        fail_total++;
        if (fail_total <= 10) $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        t_result_beat want;
        if (!i_rst_n) begin
            begin_time_r  = RST_BEGIN_TIME;
            sample_rate_r = RST_SAMPLE_RATE;
            frame_count_r = RST_FRAME_COUNT;
            curve_count_r = RST_CURVE_COUNT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BEGIN_TIME:  begin_time_r  = i_cfg_data;
                    CFG_SAMPLE_RATE: sample_rate_r = i_cfg_data;
                    CFG_FRAME_COUNT: frame_count_r = i_cfg_data[8:0];
                    CFG_CURVE_COUNT: curve_count_r = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_LOAD: begin
                        if (i_curve_sel < MAX_CURVES && i_frame_sel < MAX_FRAMES)
                            sample_shadow[i_frame_sel * MAX_CURVES + i_curve_sel] =
                                i_load_value;
                    end
                    KIND_ALL, KIND_ONE: predict_query(i_kind, i_query_time, i_curve_sel);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    note_failure($sformatf("unexpected beat: value %h curve %0d last %0d",
                                           i_sample_value, i_curve_out, i_last));
                end else begin
                    want = expected_beats.pop_front();
                    if (want.value !== i_sample_value || want.curve !== i_curve_out ||
                        want.last !== i_last)
                        note_failure($sformatf(
                            {"mismatch: exp value %h curve %0d last %0d,",
                             " got value %h curve %0d last %0d"},
                            want.value, want.curve, want.last,
                            i_sample_value, i_curve_out, i_last));
                end
            end
        end
        pending_total = expected_beats.size();
    end

endmodule

/* verif/testbench.sv */
// testbench: clock, reset and stimulus for keyframe_table_lerp_sampler_unit, with
// kflerp_checker beside the block doing prediction. Depends on kflerp_pkg.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kflerp_pkg::*;

    localparam logic [1:0]  KIND_NOP     = 2'd3;  // unused code, block drops it
    localparam int          DRAIN_CYCLES = 3 + 4 * DEF_MAX_CURVES + 8;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [31:0] ONE_SECOND   = 32'h0001_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [31:0] i_query_time;
    logic [5:0]  i_curve_sel;
    logic [7:0]  i_frame_sel;
    logic [31:0] i_load_value;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_sample_value;
    logic [5:0]  o_curve_out;
    logic        o_last;

    int          fail_count;
    int          pending;
    bit          steady;
    bit          hold_req;
    bit          written_map [DEF_MAX_FRAMES][DEF_MAX_CURVES];
    logic [31:0] cfg_begin;
    logic [31:0] cfg_rate;
    int          frames_eff;
    int          curves_eff;

    keyframe_table_lerp_sampler_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_query_time   (i_query_time),
        .i_curve_sel    (i_curve_sel),
        .i_frame_sel    (i_frame_sel),
        .i_load_value   (i_load_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_value (o_sample_value),
        .o_curve_out    (o_curve_out),
        .o_last         (o_last)
    );

    kflerp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_kind         (i_kind),
        .i_query_time   (i_query_time),
        .i_curve_sel    (i_curve_sel),
        .i_frame_sel    (i_frame_sel),
        .i_load_value   (i_load_value),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_sample_value (o_sample_value),
        .i_curve_out    (o_curve_out),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_item(input logic [1:0] kind, input logic [31:0] qt,
                             input logic [5:0] csel, input logic [7:0] fsel,
                             input logic [31:0] lval);
        while (!steady && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_query_time <= qt;
        i_curve_sel  <= csel;
        i_frame_sel  <= fsel;
        i_load_value <= lval;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic load_sample(input logic [7:0] fsel, input logic [5:0] csel,
                               input logic [31:0] lval);
        send_item(KIND_LOAD, $urandom, csel, fsel, lval);
        if (csel < DEF_MAX_CURVES) written_map[fsel][csel] = 1'b1;
    endtask

    // Wait until every predicted beat is out, then let a trailing load retire
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] t0, input logic [31:0] rate,
                              input logic [8:0] frames, input logic [6:0] curves);
        write_reg(CFG_BEGIN_TIME, t0);
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_FRAME_COUNT, {23'd0, frames});
        write_reg(CFG_CURVE_COUNT, {25'd0, curves});
        i_cfg_we   <= 1'b0;
        cfg_begin  = t0;
        cfg_rate   = rate;
        frames_eff = (frames == 0) ? 1 : (frames > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : frames;
        curves_eff = (curves == 0) ? 1 : (curves > DEF_MAX_CURVES) ? DEF_MAX_CURVES : curves;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return VAL_MAX;
            1: return VAL_MIN;
            default: return $urandom;
        endcase
    endfunction

    // Times up to two frames past the active window, some before it, or random
    function automatic logic [31:0] pick_time();
        logic [63:0] span;
        longint      offset;
        if ($urandom_range(3) == 0) return $urandom;
        if (cfg_rate == 0) span = 64'h7FFF_FFFF;
        else span = ({32'd0, 32'(frames_eff + 2)} << 32) / {32'd0, cfg_rate};
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        if (span == 0) span = 1;
        offset = longint'($urandom_range(span[31:0])) - longint'(span[31:0] / 8);
        return cfg_begin + offset[31:0];
    endfunction

    // No query may touch a table entry that was never loaded
    task automatic fill_table();
        int f;
        int c;
        for (f = 0; f < frames_eff; f++)
            for (c = 0; c < curves_eff; c++)
                if (!written_map[f][c]) load_sample(8'(f), 6'(c), rand_value());
    endtask

    task automatic run_mix(input int count);
        int         i;
        int         pick;
        logic [5:0] csel;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_item(KIND_ALL, pick_time(), 6'($urandom), 8'($urandom), $urandom);
            end else if (pick < 70) begin
                csel = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                                : 6'($urandom_range(curves_eff - 1));
                send_item(KIND_ONE, pick_time(), csel, 8'($urandom), $urandom);
            end else if (pick < 88) begin
                load_sample(8'($urandom_range(255)), 6'($urandom_range(DEF_MAX_CURVES - 1)),
                            rand_value());
            end else if (pick < 94) begin
                send_item(KIND_LOAD, $urandom, 6'($urandom_range(63, DEF_MAX_CURVES)),
                          8'($urandom), $urandom);
            end else begin
                send_item(KIND_NOP, $urandom, 6'($urandom), 8'($urandom), $urandom);
            end
        end
    endtask

    initial begin : stimulus
        int f;
        int c;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_BEGIN_TIME;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_kind       = KIND_LOAD;
        i_query_time = '0;
        i_curve_sel  = '0;
        i_frame_sel  = '0;
        i_load_value = '0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        cfg_begin    = RST_BEGIN_TIME;
        cfg_rate     = RST_SAMPLE_RATE;
        frames_eff   = RST_FRAME_COUNT;
        curves_eff   = RST_CURVE_COUNT;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: one frame, one curve
        load_sample(8'd0, 6'd0, VAL_MAX);
        load_sample(8'd255, 6'd15, VAL_MIN);
        send_item(KIND_LOAD, $urandom, 6'd63, 8'd0, $urandom);   // curve past table
        send_item(KIND_LOAD, $urandom, 6'd16, 8'd3, $urandom);
        send_item(KIND_NOP, $urandom, 6'd5, 8'd7, $urandom);
        send_item(KIND_ALL, 32'd0, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, VAL_MAX, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, VAL_MIN, 6'd63, 8'd0, 32'd0);        // curve past count
        send_item(KIND_ONE, $urandom, 6'd1, 8'd0, 32'd0);

        // zero rate and zero counts
        settle();
        set_config(32'd0, 32'd0, 9'd0, 7'd0);
        send_item(KIND_ALL, $urandom, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, $urandom, 6'd0, 8'd0, 32'd0);

        // two frames of opposite extremes: saturating extrapolation and clamping
        settle();
        set_config(32'd0, ONE_SECOND, 9'd2, 7'd64);
        for (f = 0; f < 2; f++)
            for (c = 0; c < DEF_MAX_CURVES; c++)
                load_sample(8'(f), 6'(c), ((f + c) % 2) ? VAL_MAX : VAL_MIN);
        send_item(KIND_ALL, 32'hFFFF_8000, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, 32'h0000_8000, 6'd15, 8'd0, 32'd0);
        send_item(KIND_ALL, ONE_SECOND, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, 32'h0064_0000, 6'd3, 8'd0, 32'd0);
        send_item(KIND_ONE, $urandom, 6'd16, 8'd0, 32'd0);
        send_item(KIND_ALL, VAL_MIN, 6'd0, 8'd0, 32'd0);

        // frame count above the table at 30 fps: only frames near the start and end
        // are loaded, so queries stay near both ends of the table
        settle();
        set_config(32'd0, RST_SAMPLE_RATE, 9'h1FF, 7'd1);
        load_sample(8'd1, 6'd0, rand_value());
        load_sample(8'd2, 6'd0, rand_value());
        load_sample(8'd253, 6'd0, rand_value());
        load_sample(8'd254, 6'd0, rand_value());
        load_sample(8'd255, 6'd0, VAL_MAX);
        send_item(KIND_ALL, 32'd0, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, 32'h0000_0800, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ALL, 32'h0000_1000, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, 32'hFFFF_F800, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, VAL_MIN, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ALL, 32'h0008_7333, 6'd0, 8'd0, 32'd0);  // frames 253 and 254
        send_item(KIND_ONE, 32'h0008_7800, 6'd0, 8'd0, 32'd0);  // frames 254 and 255
        send_item(KIND_ALL, 32'h0009_0000, 6'd0, 8'd0, 32'd0);  // past the last frame
        send_item(KIND_ALL, VAL_MAX, 6'd0, 8'd0, 32'd0);
        send_item(KIND_ONE, 32'h0009_0000, 6'd5, 8'd0, 32'd0);

        // many curves with the result side held off so the input stalls
        settle();
        set_config(VAL_MAX, 32'hFFFF_FFFF, 9'd4, 7'd16);
        fill_table();
        hold_req = 1'b1;
        run_mix(60);

        // curve count above the table, no idling on either side
        settle();
        set_config(VAL_MIN, 32'd1, 9'd3, 7'h7F);
        fill_table();
        steady = 1'b1;
        run_mix(60);
        steady = 1'b0;

        settle();
        set_config(32'($urandom_range(65535 * 4)), $urandom, 9'd5, 7'd3);
        fill_table();
        run_mix(30);
        settle();
        run_mix(30);

        settle();
        set_config($urandom, 32'd163840, 9'd6, 7'd5);
        fill_table();
        run_mix(40);

        settle();
        set_config($urandom, $urandom, 9'($urandom_range(6, 1)), 7'($urandom_range(16, 1)));
        fill_table();
        run_mix(35);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
